// ===== hdl/pisc_pkg.sv =====
// Shared constants and types for the PI speed controller with PWM scaling.
package pisc_pkg;

	localparam int COUNT_W    = 16;
	localparam int TARGET_W   = 14;
	localparam int GAIN_W     = 8;
	localparam int PERIOD_W   = 16;
	localparam int ERR_W      = 17;
	localparam int INTEG_W    = 12;
	localparam int DUTY_W     = 7;
	localparam int CMP_W      = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam int PROD_W     = GAIN_W + 1 + ERR_W;
	localparam int SUM_W      = PROD_W + 1;
	localparam int SCALE_W    = DUTY_W + PERIOD_W;
	localparam int RECIP_W    = 24;
	localparam int RECIP_SH   = 30;

	localparam logic [COUNT_W-1:0]  COUNT_BIAS    = 16'h7FFF;
	localparam logic [INTEG_W-1:0]  INT_CLAMP_MAX = 12'd3200;
	localparam logic [DUTY_W-1:0]   DUTY_MAX      = 7'd100;
	localparam int                  OUT_SHIFT     = 5;
	localparam logic [RECIP_W-1:0]  DUTY_RECIP    = 24'd10737419;

	localparam logic [TARGET_W-1:0] TARGET_RST = '0;
	localparam logic [GAIN_W-1:0]   PGAIN_RST  = 8'd1;
	localparam logic [GAIN_W-1:0]   IGAIN_RST  = 8'd1;
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd50;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_SPEED = 8'd0,
		REG_PROP_GAIN    = 8'd1,
		REG_INT_GAIN     = 8'd2,
		REG_PWM_PERIOD   = 8'd3
	} cfg_reg_t;

endpackage

// ===== hdl/pi_speed_controller_pwm.sv =====
// PI speed controller with anti-windup clamp and PWM compare scaling.
//
// Usage: each input beat on in_valid/in_stall carries one encoder_count sample.
// Each sample yields exactly one output beat on out_valid/out_stall with the
// duty percent, PWM compare, speed error and updated integral.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data while idle;
// indexes 0..3 are target speed, proportional gain, integral gain and PWM
// period, other indexes are ignored.
// An input beat passes through registered stages for error, integral update
// (the loop on the integral register), output sum and clamp, duty times
// period, and the reciprocal multiply that divides by 100, to the output beat.
// Throughput is one sample per cycle while the receiver does not stall.
// If out_valid is stalled, every stage holds and in_stall rises in the same
// cycle, so no beat is lost; the integral only advances when its stage moves.
// Reset clears all valids, the integral and restores register defaults.
module pi_speed_controller_pwm (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [pisc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pisc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [pisc_pkg::COUNT_W-1:0]         encoder_count,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [pisc_pkg::DUTY_W-1:0]          duty_percent,
	output logic [pisc_pkg::CMP_W-1:0]           pwm_compare,
	output logic signed [pisc_pkg::ERR_W-1:0]    speed_error,
	output logic [pisc_pkg::INTEG_W-1:0]         integral_value
);

	logic [pisc_pkg::TARGET_W-1:0] target_q;
	logic [pisc_pkg::GAIN_W-1:0]   pgain_q;
	logic [pisc_pkg::GAIN_W-1:0]   igain_q;
	logic [pisc_pkg::PERIOD_W-1:0] period_q;
	logic [pisc_pkg::INTEG_W-1:0]  integ_q;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [pisc_pkg::COUNT_W-1:0]    raw;
	logic signed [pisc_pkg::ERR_W:0] err_wide;
	logic signed [pisc_pkg::ERR_W-1:0] err_s1, err_s2, err_s3, err_s4;

	logic signed [pisc_pkg::PROD_W-1:0] iprod, pprod_s2;
	logic signed [pisc_pkg::SUM_W-1:0]  isum;
	logic [pisc_pkg::INTEG_W-1:0]       integ_next;
	logic [pisc_pkg::INTEG_W-1:0]       integ_s2, integ_s3, integ_s4;

	logic signed [pisc_pkg::SUM_W-1:0]  osum;
	logic [pisc_pkg::SUM_W-pisc_pkg::OUT_SHIFT-1:0] oquot;
	logic [pisc_pkg::DUTY_W-1:0]        duty_next, duty_s3, duty_s4;

	logic [pisc_pkg::SCALE_W-1:0]       scale_s4;
	logic [pisc_pkg::SCALE_W+pisc_pkg::RECIP_W-1:0] recip_prod;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= pisc_pkg::TARGET_RST;
			pgain_q  <= pisc_pkg::PGAIN_RST;
			igain_q  <= pisc_pkg::IGAIN_RST;
			period_q <= pisc_pkg::PERIOD_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				pisc_pkg::REG_TARGET_SPEED: target_q <= cfg_data[pisc_pkg::TARGET_W-1:0];
				pisc_pkg::REG_PROP_GAIN:    pgain_q  <= cfg_data[pisc_pkg::GAIN_W-1:0];
				pisc_pkg::REG_INT_GAIN:     igain_q  <= cfg_data[pisc_pkg::GAIN_W-1:0];
				pisc_pkg::REG_PWM_PERIOD:   period_q <= cfg_data[pisc_pkg::PERIOD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		raw      = encoder_count - pisc_pkg::COUNT_BIAS;
		err_wide = $signed({3'b000, target_q, 1'b0})
			- $signed({{2{raw[pisc_pkg::COUNT_W-1]}}, raw});
	end

	always_comb begin
		iprod = $signed({1'b0, igain_q}) * err_s1;
		isum  = $signed({{(pisc_pkg::SUM_W-pisc_pkg::INTEG_W){1'b0}}, integ_q})
			+ $signed({iprod[pisc_pkg::PROD_W-1], iprod});
		if (isum < 0) begin
			integ_next = '0;
		end else if (isum > $signed({{(pisc_pkg::SUM_W-pisc_pkg::INTEG_W){1'b0}},
				pisc_pkg::INT_CLAMP_MAX})) begin
			integ_next = pisc_pkg::INT_CLAMP_MAX;
		end else begin
			integ_next = isum[pisc_pkg::INTEG_W-1:0];
		end
	end

	always_comb begin
		osum  = $signed({pprod_s2[pisc_pkg::PROD_W-1], pprod_s2})
			+ $signed({{(pisc_pkg::SUM_W-pisc_pkg::INTEG_W){1'b0}}, integ_s2});
		oquot = osum[pisc_pkg::SUM_W-1:pisc_pkg::OUT_SHIFT];
		if (osum < 0) begin
			duty_next = '0;
		end else if (oquot > {{(pisc_pkg::SUM_W-pisc_pkg::OUT_SHIFT-pisc_pkg::DUTY_W){1'b0}},
				pisc_pkg::DUTY_MAX}) begin
			duty_next = pisc_pkg::DUTY_MAX;
		end else begin
			duty_next = oquot[pisc_pkg::DUTY_W-1:0];
		end
	end

	assign recip_prod = scale_s4 * pisc_pkg::DUTY_RECIP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
			integ_q   <= '0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			out_valid <= v_s4;
			if (v_s1) begin
				integ_q <= integ_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s1         <= err_wide[pisc_pkg::ERR_W-1:0];
			err_s2         <= err_s1;
			pprod_s2       <= $signed({1'b0, pgain_q}) * err_s1;
			integ_s2       <= integ_next;
			err_s3         <= err_s2;
			integ_s3       <= integ_s2;
			duty_s3        <= duty_next;
			err_s4         <= err_s3;
			integ_s4       <= integ_s3;
			duty_s4        <= duty_s3;
			scale_s4       <= duty_s3 * period_q;
			speed_error    <= err_s4;
			integral_value <= integ_s4;
			duty_percent   <= duty_s4;
			pwm_compare    <= recip_prod[pisc_pkg::RECIP_SH+pisc_pkg::CMP_W-1:pisc_pkg::RECIP_SH];
		end
	end

endmodule
